[rtl/rmp_pkg.sv]
// Shared types and constants for the RGB mean pooling downscaler.
package rmp_pkg;

    localparam int COL_W       = 10;   // pixel and output column counters
    localparam int ROW_W       = 10;   // pixel row counter
    localparam int WIN_CNT_W   = 4;    // in-window counters
    localparam int WIN_W       = 5;    // win register
    localparam int FRAME_W     = 11;   // frame size registers
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 16;
    localparam int NUM_CHAN    = 3;
    localparam int MAX_WIN     = 16;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int BLOCK_W     = 9;    // win*win, up to 256
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int CALC_STEPS  = RECIP_W;
    localparam int CALC_CNT_W  = $clog2(CALC_STEPS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    typedef enum logic [1:0] {
        REG_WIN,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_ACCUM,
        OP_EMIT,
        OP_ERROR
    } op_t;

    typedef enum logic [1:0] {
        CALC_LOAD,
        CALC_RUN,
        CALC_DONE
    } calc_state_t;

    typedef struct packed {
        op_t                op;
        logic               first;
        logic [COL_W-1:0]   col;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic               row_end;
        logic               frame_end;
    } queue_entry_t;

    typedef struct packed {
        logic                 busy;
        logic                 mismatch;
        logic [WIN_CNT_W-1:0] w_m1;
        logic [FRAME_W-1:0]   fw_m1;
        logic [ROW_W-1:0]     fh_m1;
        logic [RECIP_W-1:0]   recip;
    } cfg_t;

endpackage

[rtl/rmp_cfg.sv]
// Register port plus derived settings: clamps, size check and block reciprocal.
module rmp_cfg #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rmp_pkg::PADDR_W-1:0]  paddr,
    input  logic [rmp_pkg::PDATA_W-1:0]  pwdata,
    output logic [rmp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output rmp_pkg::cfg_t                cfg
);

    localparam logic [rmp_pkg::FRAME_W-1:0] WIDTH_CLIP =
        (MAX_WIDTH > (2 ** rmp_pkg::FRAME_W) - 1) ? {rmp_pkg::FRAME_W{1'b1}}
                                                  : rmp_pkg::FRAME_W'(MAX_WIDTH);

    logic [rmp_pkg::WIN_W-1:0]     win_reg;
    logic [rmp_pkg::FRAME_W-1:0]   fw_reg;
    logic [rmp_pkg::FRAME_W-1:0]   fh_reg;
    rmp_pkg::calc_state_t          state_reg, state_next;
    logic                          wr_hit;
    rmp_pkg::reg_idx_t             ridx;

    logic [rmp_pkg::WIN_W-1:0]     w_eff;
    logic [rmp_pkg::BLOCK_W-1:0]   n_eff;
    logic [rmp_pkg::FRAME_W-1:0]   fw_eff;
    logic [rmp_pkg::FRAME_W-1:0]   fh_eff;

    logic [rmp_pkg::WIN_W-1:0]     w_reg;
    logic [rmp_pkg::BLOCK_W-1:0]   n_reg;
    logic [rmp_pkg::FRAME_W-1:0]   fw_m1_reg;
    logic [rmp_pkg::ROW_W-1:0]     fh_m1_reg;
    logic [rmp_pkg::CALC_CNT_W-1:0] cnt_reg;
    logic [rmp_pkg::RECIP_W-1:0]   div_reg;
    logic [rmp_pkg::BLOCK_W-1:0]   div_rem_reg;
    logic [rmp_pkg::FRAME_W-1:0]   fwd_reg;
    logic [rmp_pkg::FRAME_W-1:0]   fhd_reg;
    logic [rmp_pkg::WIN_CNT_W-1:0] fw_rem_reg;
    logic [rmp_pkg::WIN_CNT_W-1:0] fh_rem_reg;

    logic [rmp_pkg::BLOCK_W:0]     div_sh;
    logic                          div_ge;
    logic [rmp_pkg::WIN_W-1:0]     fw_sh;
    logic [rmp_pkg::WIN_W-1:0]     fh_sh;
    logic                          fw_ge;
    logic                          fh_ge;
    logic                          mod_active;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite;
    assign ridx   = rmp_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= rmp_pkg::WIN_W'(2);
            fw_reg  <= rmp_pkg::FRAME_W'(1024);
            fh_reg  <= rmp_pkg::FRAME_W'(1024);
        end
        else if (wr_hit)
        begin
            case (ridx)
                rmp_pkg::REG_WIN:          win_reg <= pwdata[rmp_pkg::WIN_W-1:0];
                rmp_pkg::REG_FRAME_WIDTH:  fw_reg  <= pwdata[rmp_pkg::FRAME_W-1:0];
                rmp_pkg::REG_FRAME_HEIGHT: fh_reg  <= pwdata[rmp_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            rmp_pkg::REG_WIN:          prdata = rmp_pkg::PDATA_W'(win_reg);
            rmp_pkg::REG_FRAME_WIDTH:  prdata = rmp_pkg::PDATA_W'(fw_reg);
            rmp_pkg::REG_FRAME_HEIGHT: prdata = rmp_pkg::PDATA_W'(fh_reg);
            default:                   prdata = '0;
        endcase
    end

    // clamp the raw registers into their legal ranges
    always_comb
    begin
        if (win_reg == '0)
            w_eff = rmp_pkg::WIN_W'(1);
        else if (win_reg > rmp_pkg::WIN_W'(rmp_pkg::MAX_WIN))
            w_eff = rmp_pkg::WIN_W'(rmp_pkg::MAX_WIN);
        else
            w_eff = win_reg;

        n_eff = rmp_pkg::BLOCK_W'(w_eff) * rmp_pkg::BLOCK_W'(w_eff);

        if (fw_reg == '0)
            fw_eff = rmp_pkg::FRAME_W'(1);
        else if (fw_reg > WIDTH_CLIP)
            fw_eff = WIDTH_CLIP;
        else
            fw_eff = fw_reg;

        if (fh_reg == '0)
            fh_eff = rmp_pkg::FRAME_W'(1);
        else if (fh_reg > rmp_pkg::FRAME_W'(rmp_pkg::HEIGHT_LIMIT))
            fh_eff = rmp_pkg::FRAME_W'(rmp_pkg::HEIGHT_LIMIT);
        else
            fh_eff = fh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rmp_pkg::CALC_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmp_pkg::CALC_LOAD: state_next = rmp_pkg::CALC_RUN;
            rmp_pkg::CALC_RUN:
            begin
                if (cnt_reg == rmp_pkg::CALC_CNT_W'(rmp_pkg::CALC_STEPS - 1))
                    state_next = rmp_pkg::CALC_DONE;
            end
            rmp_pkg::CALC_DONE: state_next = rmp_pkg::CALC_DONE;
            default:            state_next = rmp_pkg::CALC_LOAD;
        endcase
        // restart the derivation after any register write
        if (wr_hit)
            state_next = rmp_pkg::CALC_LOAD;
    end

    // one restoring step per cycle: reciprocal ceil(2^24/n), and remainders of
    // width and height by win during the first FRAME_W steps
    assign div_sh     = {div_rem_reg, div_reg[rmp_pkg::RECIP_W-1]};
    assign div_ge     = div_sh >= {1'b0, n_reg};
    assign mod_active = cnt_reg < rmp_pkg::CALC_CNT_W'(rmp_pkg::FRAME_W);
    assign fw_sh      = {fw_rem_reg, fwd_reg[rmp_pkg::FRAME_W-1]};
    assign fh_sh      = {fh_rem_reg, fhd_reg[rmp_pkg::FRAME_W-1]};
    assign fw_ge      = fw_sh >= w_reg;
    assign fh_ge      = fh_sh >= w_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == rmp_pkg::CALC_LOAD)
        begin
            w_reg       <= w_eff;
            n_reg       <= n_eff;
            fw_m1_reg   <= fw_eff - rmp_pkg::FRAME_W'(1);
            fh_m1_reg   <= rmp_pkg::ROW_W'(fh_eff - rmp_pkg::FRAME_W'(1));
            cnt_reg     <= '0;
            div_reg     <= (rmp_pkg::RECIP_W'(1) << rmp_pkg::RECIP_SHIFT)
                           + rmp_pkg::RECIP_W'(n_eff - rmp_pkg::BLOCK_W'(1));
            div_rem_reg <= '0;
            fwd_reg     <= fw_eff;
            fhd_reg     <= fh_eff;
            fw_rem_reg  <= '0;
            fh_rem_reg  <= '0;
        end
        else if (state_reg == rmp_pkg::CALC_RUN)
        begin
            cnt_reg     <= cnt_reg + rmp_pkg::CALC_CNT_W'(1);
            div_reg     <= {div_reg[rmp_pkg::RECIP_W-2:0], div_ge};
            div_rem_reg <= div_ge ? rmp_pkg::BLOCK_W'(div_sh - {1'b0, n_reg})
                                  : div_sh[rmp_pkg::BLOCK_W-1:0];
            if (mod_active)
            begin
                fwd_reg    <= fwd_reg << 1;
                fhd_reg    <= fhd_reg << 1;
                fw_rem_reg <= fw_ge ? rmp_pkg::WIN_CNT_W'(fw_sh - w_reg)
                                    : fw_sh[rmp_pkg::WIN_CNT_W-1:0];
                fh_rem_reg <= fh_ge ? rmp_pkg::WIN_CNT_W'(fh_sh - w_reg)
                                    : fh_sh[rmp_pkg::WIN_CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        cfg.busy     = state_reg != rmp_pkg::CALC_DONE;
        cfg.mismatch = (fw_rem_reg != '0) || (fh_rem_reg != '0);
        cfg.w_m1     = rmp_pkg::WIN_CNT_W'(w_reg - rmp_pkg::WIN_W'(1));
        cfg.fw_m1    = fw_m1_reg;
        cfg.fh_m1    = fh_m1_reg;
        cfg.recip    = div_reg;
    end

endmodule

[rtl/rmp_front.sv]
// Front end: accepts pixels, runs the raster counters and classifies each word.
module rmp_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  logic [rmp_pkg::CHAN_W-1:0]   blue,
    input  logic [rmp_pkg::CHAN_W-1:0]   green,
    input  logic [rmp_pkg::CHAN_W-1:0]   red,
    input  rmp_pkg::cfg_t                cfg,
    input  logic                         queue_full,
    output logic                         push,
    output rmp_pkg::queue_entry_t        entry
);

    logic [rmp_pkg::COL_W-1:0]     pcol_reg, pcol_next;
    logic [rmp_pkg::ROW_W-1:0]     prow_reg, prow_next;
    logic [rmp_pkg::WIN_CNT_W-1:0] riw_reg, riw_next;
    logic [rmp_pkg::WIN_CNT_W-1:0] ciw_reg, ciw_next;
    logic [rmp_pkg::COL_W-1:0]     ocol_reg, ocol_next;
    logic                          accept;
    logic                          last_col;
    logic                          last_row;
    logic                          block_done;

    assign pixel_stall = cfg.busy || queue_full;
    assign accept      = pixel_valid && !pixel_stall;
    assign last_col    = {1'b0, pcol_reg} >= cfg.fw_m1;
    assign last_row    = prow_reg >= cfg.fh_m1;
    assign block_done  = (riw_reg == cfg.w_m1) && (ciw_reg == cfg.w_m1);

    always_comb
    begin
        entry.first     = (riw_reg == '0) && (ciw_reg == '0);
        entry.col       = ocol_reg;
        entry.blue      = blue;
        entry.green     = green;
        entry.red       = red;
        entry.row_end   = last_col;
        entry.frame_end = last_col && last_row;
        if (cfg.mismatch)
            entry.op = rmp_pkg::OP_ERROR;
        else if (block_done)
            entry.op = rmp_pkg::OP_EMIT;
        else
            entry.op = rmp_pkg::OP_ACCUM;

        // a bad frame size yields one flagged word at the top-left pixel only
        push = accept && (!cfg.mismatch || ((pcol_reg == '0) && (prow_reg == '0)));
    end

    always_comb
    begin
        pcol_next = pcol_reg;
        prow_next = prow_reg;
        riw_next  = riw_reg;
        ciw_next  = ciw_reg;
        ocol_next = ocol_reg;
        if (last_col)
        begin
            pcol_next = '0;
            ciw_next  = '0;
            ocol_next = '0;
            if (last_row)
            begin
                prow_next = '0;
                riw_next  = '0;
            end
            else
            begin
                prow_next = prow_reg + rmp_pkg::ROW_W'(1);
                riw_next  = (riw_reg >= cfg.w_m1) ? '0 : riw_reg + rmp_pkg::WIN_CNT_W'(1);
            end
        end
        else
        begin
            pcol_next = pcol_reg + rmp_pkg::COL_W'(1);
            if (ciw_reg >= cfg.w_m1)
            begin
                ciw_next  = '0;
                ocol_next = ocol_reg + rmp_pkg::COL_W'(1);
            end
            else
            begin
                ciw_next = ciw_reg + rmp_pkg::WIN_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg <= '0;
            prow_reg <= '0;
            riw_reg  <= '0;
            ciw_reg  <= '0;
            ocol_reg <= '0;
        end
        else if (accept)
        begin
            pcol_reg <= pcol_next;
            prow_reg <= prow_next;
            riw_reg  <= riw_next;
            ciw_reg  <= ciw_next;
            ocol_reg <= ocol_next;
        end
    end

endmodule

[rtl/rmp_fifo.sv]
// Short word queue between the front end and the accumulate/divide back end.
module rmp_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rmp_pkg::queue_entry_t  push_entry,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output rmp_pkg::queue_entry_t  head
);

    rmp_pkg::queue_entry_t          slots_reg [rmp_pkg::QUEUE_DEPTH];
    logic [rmp_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rmp_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rmp_pkg::QPTR_W:0]       count_reg;

    assign full      = count_reg == (rmp_pkg::QPTR_W + 1)'(rmp_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + rmp_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + rmp_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (rmp_pkg::QPTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (rmp_pkg::QPTR_W + 1)'(1);
        end
    end

endmodule

[rtl/rmp_back.sv]
// Back end: column-sum read-modify-write, reciprocal divide and output register.
module rmp_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_not_empty,
    input  rmp_pkg::queue_entry_t         head,
    output logic                          pop,
    input  logic [rmp_pkg::RECIP_W-1:0]   recip,
    output logic                          pool_valid,
    input  logic                          pool_stall,
    output logic [rmp_pkg::CHAN_W-1:0]    blue_mean,
    output logic [rmp_pkg::CHAN_W-1:0]    green_mean,
    output logic [rmp_pkg::CHAN_W-1:0]    red_mean,
    output logic                          row_end,
    output logic                          frame_end,
    output logic                          size_error
);

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WORD_W = rmp_pkg::NUM_CHAN * rmp_pkg::SUM_W;
    localparam int PROD_W = rmp_pkg::SUM_W + rmp_pkg::RECIP_W;

    typedef logic [rmp_pkg::NUM_CHAN-1:0][rmp_pkg::SUM_W-1:0] sums_t;

    logic [WORD_W-1:0]             mem [MAX_WIDTH];
    logic                          adv;

    logic                          s1_valid_reg;
    rmp_pkg::queue_entry_t         s1_reg;
    sums_t                         rd_q_reg;

    logic                          wr_valid_reg;
    logic [rmp_pkg::COL_W-1:0]     wr_col_reg;
    sums_t                         wr_data_reg;

    logic                          s2_valid_reg;
    sums_t                         s2_sum_reg;
    logic                          s2_row_end_reg;
    logic                          s2_frame_end_reg;
    logic                          s2_error_reg;

    logic                          out_valid_reg;
    logic [rmp_pkg::CHAN_W-1:0]    out_mean_reg [rmp_pkg::NUM_CHAN];
    logic                          out_row_end_reg;
    logic                          out_frame_end_reg;
    logic                          out_error_reg;

    sums_t                         base;
    sums_t                         sum;
    sums_t                         px;
    logic                          wr_en;
    logic                          s1_emits;
    logic [PROD_W-1:0]             prod [rmp_pkg::NUM_CHAN];

    // whole back end moves together; it advances whenever the output slot frees
    assign adv = !out_valid_reg || !pool_stall;
    assign pop = adv && queue_not_empty;

    always_comb
    begin
        px[0] = rmp_pkg::SUM_W'(s1_reg.blue);
        px[1] = rmp_pkg::SUM_W'(s1_reg.green);
        px[2] = rmp_pkg::SUM_W'(s1_reg.red);
        // forward the last write: the store read was taken before that write landed
        if (s1_reg.first)
            base = '0;
        else if (wr_valid_reg && (wr_col_reg == s1_reg.col))
            base = wr_data_reg;
        else
            base = rd_q_reg;
        for (int c = 0; c < rmp_pkg::NUM_CHAN; c++)
            sum[c] = base[c] + px[c];
        wr_en    = adv && s1_valid_reg && (s1_reg.op inside {rmp_pkg::OP_ACCUM, rmp_pkg::OP_EMIT});
        s1_emits = s1_valid_reg && (s1_reg.op inside {rmp_pkg::OP_EMIT, rmp_pkg::OP_ERROR});
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(s1_reg.col)] <= sum;
        if (pop)
            rd_q_reg <= mem[AW'(head.col)];
    end

    always_comb
    begin
        for (int c = 0; c < rmp_pkg::NUM_CHAN; c++)
            prod[c] = PROD_W'(s2_sum_reg[c]) * PROD_W'(recip);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_reg <= head;
        if (wr_en)
        begin
            wr_col_reg  <= s1_reg.col;
            wr_data_reg <= sum;
        end
        if (adv)
        begin
            s2_sum_reg       <= (s1_reg.op == rmp_pkg::OP_ERROR) ? '0 : sum;
            s2_row_end_reg   <= s1_reg.row_end && (s1_reg.op != rmp_pkg::OP_ERROR);
            s2_frame_end_reg <= s1_reg.frame_end && (s1_reg.op != rmp_pkg::OP_ERROR);
            s2_error_reg     <= s1_reg.op == rmp_pkg::OP_ERROR;
            for (int c = 0; c < rmp_pkg::NUM_CHAN; c++)
                out_mean_reg[c] <= prod[c][rmp_pkg::RECIP_SHIFT +: rmp_pkg::CHAN_W];
            out_row_end_reg   <= s2_row_end_reg;
            out_frame_end_reg <= s2_frame_end_reg;
            out_error_reg     <= s2_error_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= pop;
                s2_valid_reg  <= s1_emits;
                out_valid_reg <= s2_valid_reg;
            end
            if (wr_en)
                wr_valid_reg <= 1'b1;
        end
    end

    assign pool_valid = out_valid_reg;
    assign blue_mean  = out_mean_reg[0];
    assign green_mean = out_mean_reg[1];
    assign red_mean   = out_mean_reg[2];
    assign row_end    = out_row_end_reg;
    assign frame_end  = out_frame_end_reg;
    assign size_error = out_error_reg;

endmodule

[rtl/rgb_mean_pooling_downscale_top.sv]
// A pooled word passes through the queue, the s1 and s2 registers and the output register.
// Throughput: one pixel per cycle while pixel_stall is low; the front end runs ahead through a 4-word queue.
// After reset and after every register write the pixel input stalls
// while a serial unit derives the block reciprocal and the frame size check.
// Reset clears counters, queue and valids; the column-sum store is not cleared,
// since each entry is written on the first row of its window band before use.
module rgb_mean_pooling_downscale_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmp_pkg::PADDR_W-1:0]   paddr,
    input  logic [rmp_pkg::PDATA_W-1:0]   pwdata,
    output logic [rmp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic [rmp_pkg::CHAN_W-1:0]    blue,
    input  logic [rmp_pkg::CHAN_W-1:0]    green,
    input  logic [rmp_pkg::CHAN_W-1:0]    red,
    output logic                          pool_valid,
    input  logic                          pool_stall,
    output logic [rmp_pkg::CHAN_W-1:0]    blue_mean,
    output logic [rmp_pkg::CHAN_W-1:0]    green_mean,
    output logic [rmp_pkg::CHAN_W-1:0]    red_mean,
    output logic                          row_end,
    output logic                          frame_end,
    output logic                          size_error
);

    rmp_pkg::cfg_t          cfg;
    rmp_pkg::queue_entry_t  push_entry;
    rmp_pkg::queue_entry_t  head;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_not_empty;

    rmp_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rmp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .cfg         (cfg),
        .queue_full  (queue_full),
        .push        (push),
        .entry       (push_entry)
    );

    rmp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (head)
    );

    rmp_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .recip           (cfg.recip),
        .pool_valid      (pool_valid),
        .pool_stall      (pool_stall),
        .blue_mean       (blue_mean),
        .green_mean      (green_mean),
        .red_mean        (red_mean),
        .row_end         (row_end),
        .frame_end       (frame_end),
        .size_error      (size_error)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("queue written while full");

    a_stall_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> pixel_stall)
        else $error("pixel taken while settings are being derived");

    a_error_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pool_valid && size_error) |->
            (blue_mean == '0 && green_mean == '0 && red_mean == '0 && !row_end && !frame_end))
        else $error("size error word carries data");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pool_valid && frame_end) |-> row_end)
        else $error("frame end without row end");

endmodule

[dv/tb.sv]
// Self-checking testbench for the RGB mean pooling downscaler: directed and random frames.
`timescale 1ns / 100ps

module tb;
    import rmp_pkg::*;

    localparam int MAX_WIDTH   = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NO_HOLD     = -1;
    localparam int DRAIN_WAIT  = 16;

    typedef enum int {
        FILL_MIXED,
        FILL_EDGES,
        FILL_FULL
    } fill_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              row_end;
        logic              frame_end;
        logic              size_error;
    } pooled_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                pixel_valid;
    logic                pixel_stall;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   red;
    logic                pool_valid;
    logic                pool_stall;
    logic [CHAN_W-1:0]   blue_mean;
    logic [CHAN_W-1:0]   green_mean;
    logic [CHAN_W-1:0]   red_mean;
    logic                row_end;
    logic                frame_end;
    logic                size_error;

    // Predictor state: register copies, column-sum store and raster counters
    logic [WIN_W-1:0]     cfg_win;
    logic [FRAME_W-1:0]   cfg_fw;
    logic [FRAME_W-1:0]   cfg_fh;
    logic [SUM_W-1:0]     band_sum [MAX_WIDTH][NUM_CHAN];
    logic [COL_W-1:0]     px_col;
    logic [ROW_W-1:0]     px_row;
    logic [WIN_CNT_W-1:0] row_in_win;
    logic [WIN_CNT_W-1:0] col_in_win;
    logic [COL_W-1:0]     out_col;

    pooled_t pooled_due[$];

    int  err_count;
    int  cycles;
    int  pixels_sent;
    int  pooled_seen;
    int  errors_seen;
    int  frames_sent;
    int  settings_used;
    bit  idle_on;

    rgb_mean_pooling_downscale_top #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .pool_valid  (pool_valid),
        .pool_stall  (pool_stall),
        .blue_mean   (blue_mean),
        .green_mean  (green_mean),
        .red_mean    (red_mean),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .size_error  (size_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycles, what);
        err_count++;
    endtask

    function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predictor by one accepted pixel; queue the pooled word it closes, if any.
    function automatic void pool_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                                       input logic [CHAN_W-1:0] r);
        int unsigned       w;
        int unsigned       fw;
        int unsigned       fh;
        int unsigned       n;
        logic              mismatch;
        logic              last_col;
        logic              last_row;
        logic              first;
        logic [CHAN_W-1:0] px [NUM_CHAN];
        logic [CHAN_W-1:0] mean [NUM_CHAN];
        pooled_t           res;

        px[0] = b;
        px[1] = g;
        px[2] = r;
        w  = clamp_cfg(cfg_win, MAX_WIN);
        fw = clamp_cfg(cfg_fw, MAX_WIDTH);
        fh = clamp_cfg(cfg_fh, HEIGHT_LIMIT);
        mismatch = (fw % w != 0) || (fh % w != 0);
        last_col = px_col >= fw - 1;
        last_row = px_row >= fh - 1;
        res = '0;

        if (mismatch) begin
            // only the frame's first pixel reports, the sums stay untouched
            if (px_col == 0 && px_row == 0) begin
                res.size_error = 1'b1;
                pooled_due.push_back(res);
            end
        end
        else begin
            first = row_in_win == 0 && col_in_win == 0;
            for (int c = 0; c < NUM_CHAN; c++)
                band_sum[out_col][c] = first ? {8'h00, px[c]}
                                             : band_sum[out_col][c] + {8'h00, px[c]};
            if (row_in_win == w - 1 && col_in_win == w - 1) begin
                n = w * w;
                for (int c = 0; c < NUM_CHAN; c++)
                    mean[c] = CHAN_W'(band_sum[out_col][c] / n);
                res.blue      = mean[0];
                res.green     = mean[1];
                res.red       = mean[2];
                res.row_end   = last_col;
                res.frame_end = last_col && last_row;
                pooled_due.push_back(res);
            end
        end

        if (last_col) begin
            px_col     = '0;
            col_in_win = '0;
            out_col    = '0;
            if (last_row) begin
                px_row     = '0;
                row_in_win = '0;
            end
            else begin
                px_row = px_row + 1'b1;
                if (row_in_win >= w - 1)
                    row_in_win = '0;
                else
                    row_in_win = row_in_win + 1'b1;
            end
        end
        else begin
            px_col = px_col + 1'b1;
            if (col_in_win >= w - 1) begin
                col_in_win = '0;
                out_col    = out_col + 1'b1;
            end
            else
                col_in_win = col_in_win + 1'b1;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r);
        if (idle_on && $urandom_range(0, 99) < 12) begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        blue        <= b;
        green       <= g;
        red         <= r;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pool_pixel(b, g, r);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait until every pooled word is back, then hold for the extra wait asked for.
    task automatic settle(input int extra);
        pixel_valid <= 1'b0;
        @(negedge clk);
        while (pooled_due.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic apb_access(input logic is_write, input reg_idx_t idx,
                              input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] held;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (is_write) begin
            case (idx)
                REG_WIN:          cfg_win = data[WIN_W-1:0];
                REG_FRAME_WIDTH:  cfg_fw  = data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: cfg_fh  = data[FRAME_W-1:0];
                default: ;
            endcase
        end
        else begin
            held = '0;
            case (idx)
                REG_WIN:          held[WIN_W-1:0]   = cfg_win;
                REG_FRAME_WIDTH:  held[FRAME_W-1:0] = cfg_fw;
                REG_FRAME_HEIGHT: held[FRAME_W-1:0] = cfg_fh;
                default: ;
            endcase
            if (prdata !== held)
                flag_mismatch($sformatf("register %s read %h, expected %h",
                                        idx.name(), prdata, held));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned fw, input int unsigned fh);
        settle(DRAIN_WAIT);
        apb_access(1'b1, REG_WIN, w);
        apb_access(1'b1, REG_FRAME_WIDTH, fw);
        apb_access(1'b1, REG_FRAME_HEIGHT, fh);
        apb_access(1'b0, REG_WIN, '0);
        apb_access(1'b0, REG_FRAME_WIDTH, '0);
        apb_access(1'b0, REG_FRAME_HEIGHT, '0);
        settings_used++;
    endtask

    function automatic logic [CHAN_W-1:0] chan_value(input fill_t fill);
        if (fill == FILL_FULL)
            return '1;
        if (fill == FILL_EDGES)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one whole frame at the current size; hold at pixel hold_at until drained.
    task automatic send_frame(input int hold_at, input fill_t fill);
        int npix;

        npix = clamp_cfg(cfg_fw, MAX_WIDTH) * clamp_cfg(cfg_fh, HEIGHT_LIMIT);
        for (int i = 0; i < npix; i++) begin
            if (i == hold_at)
                settle(0);
            push_pixel(chan_value(fill), chan_value(fill), chan_value(fill));
        end
        frames_sent++;
    endtask

    // Compare each accepted pooled word against the oldest one predicted
    always @(posedge clk)
    begin : check_pooled
        pooled_t want;

        if (rst_n && pool_valid && !pool_stall) begin
            if (pooled_due.size() == 0)
                flag_mismatch("pooled word arrived with none predicted");
            else begin
                want = pooled_due.pop_front();
                pooled_seen++;
                if (want.size_error)
                    errors_seen++;
                if (blue_mean !== want.blue)
                    flag_mismatch($sformatf("blue_mean %0d, expected %0d", blue_mean, want.blue));
                if (green_mean !== want.green)
                    flag_mismatch($sformatf("green_mean %0d, expected %0d",
                                            green_mean, want.green));
                if (red_mean !== want.red)
                    flag_mismatch($sformatf("red_mean %0d, expected %0d", red_mean, want.red));
                if (row_end !== want.row_end)
                    flag_mismatch($sformatf("row_end %b, expected %b", row_end, want.row_end));
                if (frame_end !== want.frame_end)
                    flag_mismatch($sformatf("frame_end %b, expected %b",
                                            frame_end, want.frame_end));
                if (size_error !== want.size_error)
                    flag_mismatch($sformatf("size_error %b, expected %b",
                                            size_error, want.size_error));
            end
        end
    end

    always @(negedge clk)
        pool_stall <= idle_on && ($urandom_range(0, 99) < 15);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d pooled words outstanding",
                     pooled_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_register_reset;
        apb_access(1'b0, REG_WIN, '0);
        apb_access(1'b0, REG_FRAME_WIDTH, '0);
        apb_access(1'b0, REG_FRAME_HEIGHT, '0);
    endtask

    task automatic test_directed;
        // window of one: darkest and brightest pixel pass straight through
        set_frame(1, 2, 1);
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        // 2x2 block, means round down
        set_frame(2, 2, 2);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'hFF, 8'h00, 8'h80);
        push_pixel(8'hFF, 8'hFF, 8'h01);
        push_pixel(8'hFE, 8'hFF, 8'h00);
        // width not a multiple of the window
        set_frame(2, 3, 2);
        send_frame(NO_HOLD, FILL_EDGES);
        // height not a multiple of the window
        set_frame(2, 2, 1);
        send_frame(NO_HOLD, FILL_EDGES);
        // zero window and zero sizes act as one
        set_frame(0, 0, 0);
        push_pixel(8'h80, 8'h7F, 8'h01);
        // oversized window saturates to the maximum
        set_frame(31, 2, 1);
        send_frame(NO_HOLD, FILL_EDGES);
    endtask

    task automatic test_window_max;
        set_frame(MAX_WIN, 16, 16);
        send_frame(NO_HOLD, FILL_FULL);
    endtask

    task automatic test_frame_limits;
        // width above the maximum clamps to a full line
        set_frame(0, 2047, 1);
        send_frame(NO_HOLD, FILL_MIXED);
        set_frame(1, 1, HEIGHT_LIMIT);
        send_frame(NO_HOLD, FILL_MIXED);
    endtask

    task automatic test_steady_stream;
        idle_on = 1'b0;
        set_frame(1, 8, 4);
        send_frame(NO_HOLD, FILL_MIXED);
        set_frame(2, 8, 4);
        send_frame(NO_HOLD, FILL_MIXED);
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames;
        int          px0;
        int          pooled0;
        int unsigned w;
        int unsigned fw;
        int unsigned fh;
        int          npix;
        bit          first_hold;

        px0        = pixels_sent;
        pooled0    = pooled_seen;
        first_hold = 1'b1;
        while (pixels_sent - px0 < 400 || pooled_seen - pooled0 < 40) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_WIN) : $urandom_range(1, 4);
            if ($urandom_range(0, 6) == 0) begin
                fw = $urandom_range(1, 12);
                fh = $urandom_range(1, 6);
            end
            else begin
                fw = w * $urandom_range(1, (w > 4) ? 1 : 16 / w);
                fh = w * $urandom_range(1, (w > 4) ? 1 : 8 / w);
            end
            set_frame(w, fw, fh);
            npix = clamp_cfg(fw, MAX_WIDTH) * clamp_cfg(fh, HEIGHT_LIMIT);
            repeat ($urandom_range(1, 2)) begin
                // hold the sender at a random pixel of the frame until all pooled words are out
                if (first_hold || $urandom_range(0, 3) == 0)
                    send_frame($urandom_range(0, npix - 1), FILL_MIXED);
                else
                    send_frame(NO_HOLD, FILL_MIXED);
                first_hold = 1'b0;
            end
        end
    endtask

    initial
    begin
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        pixel_valid = 1'b0;
        blue        = '0;
        green       = '0;
        red         = '0;
        pool_stall  = 1'b0;
        rst_n       = 1'b0;
        idle_on     = 1'b1;
        err_count   = 0;
        cycles      = 0;
        pixels_sent = 0;
        pooled_seen = 0;
        errors_seen = 0;
        frames_sent = 0;
        settings_used = 0;
        cfg_win     = WIN_W'(2);
        cfg_fw      = FRAME_W'(1024);
        cfg_fh      = FRAME_W'(1024);
        px_col      = '0;
        px_row      = '0;
        row_in_win  = '0;
        col_in_win  = '0;
        out_col     = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset;
        test_directed;
        test_window_max;
        test_frame_limits;
        test_steady_stream;
        test_random_frames;

        settle(2 * DRAIN_WAIT);
        $display("Covered %0d pixels in %0d frames over %0d register settings, window 1 to 16",
                 pixels_sent, frames_sent, settings_used);
        $display("Checked %0d pooled words, %0d of them size errors", pooled_seen, errors_seen);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/rmp_pkg.sv
rtl/rmp_cfg.sv
rtl/rmp_front.sv
rtl/rmp_fifo.sv
rtl/rmp_back.sv
rtl/rgb_mean_pooling_downscale_top.sv
dv/tb.sv
